### rtl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg: shared types and codes of the address region table
// Command and status codes, item structs, table entry and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_CHECK  = 3'd3;
  localparam logic [2:0] CMD_UNMAP  = 3'd4;
  localparam logic [2:0] CMD_MAP    = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_MISS    = 3'd4;
  localparam logic [2:0] ST_NOSPACE = 3'd5;

  localparam logic CFG_WIN_BASE = 1'b0;
  localparam logic CFG_WIN_END  = 1'b1;

  localparam logic [31:0] WIN_BASE_RST = 32'h2000_0000;
  localparam logic [31:0] WIN_END_RST  = 32'h3f00_0000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] address;
    logic [31:0] end_address;
    logic [31:0] length;
    logic [2:0]  permissions;
    logic        fixed_place;
  } item_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [3:0]  region_index;
    logic [2:0]  region_permissions;
    logic        span_changed;
  } item_out_t;

  typedef struct packed {
    logic [31:0] lo_a;
    logic [31:0] hi_a;
    logic [2:0]  perm;
  } entry_t;

  typedef enum logic [2:0] {
    SC_ADD, SC_LOOK, SC_CHECK, SC_UNMAP, SC_HINT, SC_FIT
  } scan_e;

  typedef enum logic [3:0] {
    A_NONE, A_LOAD, A_CLEAR, A_ADDSET, A_PREP, A_READ, A_NEXT, A_CHAIN,
    A_FITINIT, A_UNMAP, A_SPLIT1, A_SPLIT2, A_ALLOC, A_LOOKOK, A_FINISH
  } act_e;

  typedef struct packed {
    act_e       act;
    scan_e      scan;
    logic       mark;
    logic [2:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       fixed;
    logic       add_bad;
    logic       check_bad;
    logic       unmap_bad;
    logic       map_bad;
    logic       hint_ok;
    logic       fit_over;
    logic       hit;
    logic       last;
    logic       iter_last;
    logic       perm_ok;
    logic       chain_done;
    logic       split;
    logic       free_none;
  } dp_stat_t;

endpackage

### rtl/art_dp.sv
// ----------------------------------------------------------------------------
// art_dp: address region table datapath
// Region memory, valid bits, window registers, span operands, slot scan
// counters and the result register.
// ----------------------------------------------------------------------------
module art_dp #(
  parameter int REGION_SLOTS = 16,
  parameter int PAGE_BITS    = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  art_pkg::item_in_t  in_item_i,
  output art_pkg::item_out_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  art_pkg::dp_cmd_t   cmd_i,
  output art_pkg::dp_stat_t  stat_o
);

  localparam int IW  = $clog2(REGION_SLOTS);
  localparam int ITW = $clog2(REGION_SLOTS + 1);
  localparam logic [32:0] PMASK = (33'd1 << PAGE_BITS) - 33'd1;

  art_pkg::entry_t    mem [REGION_SLOTS];
  art_pkg::entry_t    rd_q;
  art_pkg::item_in_t  item_q;
  art_pkg::item_out_t out_q;
  logic [REGION_SLOTS-1:0] valid_q;
  logic [31:0] wbase_q, wend_q;
  logic [32:0] lo_q, rlen_q;
  logic [33:0] hi_q;
  logic [IW-1:0]  idx_q, spare_slot;
  logic [ITW-1:0] iter_q;
  logic [IW-1:0]  ridx_q;
  logic [2:0]     rperm_q;
  logic           chg_q;
  logic           we, free_none, full_cover, contain, overlap;
  logic [IW-1:0]  waddr;
  art_pkg::entry_t wdata;
  logic [32:0] st33, en33;
  logic [33:0] en34, wend34;

  assign st33   = {1'b0, rd_q.lo_a};
  assign en33   = {1'b0, rd_q.hi_a};
  assign en34   = {2'b00, rd_q.hi_a};
  assign wend34 = {2'b00, wend_q};

  assign contain    = (lo_q >= st33) && (lo_q < en33);
  assign overlap    = (lo_q < en33) && (hi_q > {1'b0, st33});
  assign full_cover = (lo_q <= st33) && (hi_q >= en34);

  always_comb begin
    spare_slot = '0;
    for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) spare_slot = IW'(i);
    end
  end
  assign free_none = &valid_q;

  always_comb begin
    stat_o.cmd        = item_q.cmd;
    stat_o.fixed      = item_q.fixed_place;
    stat_o.add_bad    = ({1'b0, lo_q} >= hi_q) || (lo_q[PAGE_BITS-1:0] != '0)
                        || (hi_q[PAGE_BITS-1:0] != '0);
    stat_o.check_bad  = (item_q.length == '0) || (hi_q[33:32] != 2'b00);
    stat_o.unmap_bad  = (item_q.address[PAGE_BITS-1:0] != '0) || (item_q.length == '0)
                        || (hi_q > wend34) || (item_q.address < wbase_q);
    stat_o.map_bad    = (item_q.length == '0) || (item_q.permissions == 3'b000);
    stat_o.hint_ok    = (item_q.address != '0) && (item_q.address[PAGE_BITS-1:0] == '0)
                        && (item_q.address >= wbase_q) && (hi_q <= wend34);
    stat_o.fit_over   = hi_q > wend34;
    stat_o.hit        = valid_q[idx_q] &&
                        ((cmd_i.scan == art_pkg::SC_LOOK || cmd_i.scan == art_pkg::SC_CHECK)
                         ? contain : overlap);
    stat_o.last       = idx_q == IW'(REGION_SLOTS - 1);
    stat_o.iter_last  = iter_q == ITW'(REGION_SLOTS);
    stat_o.perm_ok    = (rd_q.perm & item_q.permissions) == item_q.permissions;
    stat_o.chain_done = hi_q <= en34;
    stat_o.split      = (lo_q > st33) && (hi_q < en34);
    stat_o.free_none  = free_none;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = rd_q;
    case (cmd_i.act)
      art_pkg::A_UNMAP: begin
        we = !full_cover;
        if (lo_q <= st33) wdata.lo_a = hi_q[31:0];
        else wdata.hi_a = lo_q[31:0];
      end
      art_pkg::A_SPLIT1: begin
        we         = 1'b1;
        waddr      = spare_slot;
        wdata.lo_a = hi_q[31:0];
      end
      art_pkg::A_SPLIT2: begin
        we         = 1'b1;
        wdata.hi_a = lo_q[31:0];
      end
      art_pkg::A_ALLOC: begin
        we    = 1'b1;
        waddr = spare_slot;
        wdata = '{lo_a: lo_q[31:0], hi_a: hi_q[31:0], perm: item_q.permissions};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.act == art_pkg::A_READ) rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      wbase_q <= art_pkg::WIN_BASE_RST;
      wend_q  <= art_pkg::WIN_END_RST;
    end else begin
      if (cfg_we_i && cfg_index_i == art_pkg::CFG_WIN_BASE) wbase_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == art_pkg::CFG_WIN_END) wend_q <= cfg_data_i;
      case (cmd_i.act)
        art_pkg::A_CLEAR:  valid_q <= '0;
        art_pkg::A_UNMAP:  if (full_cover) valid_q[idx_q] <= 1'b0;
        art_pkg::A_SPLIT1: valid_q[spare_slot] <= 1'b1;
        art_pkg::A_ALLOC:  valid_q[spare_slot] <= 1'b1;
        default: valid_q <= valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark) chg_q <= 1'b1;
    case (cmd_i.act)
      art_pkg::A_LOAD: begin
        item_q  <= in_item_i;
        rlen_q  <= ({1'b0, in_item_i.length} + PMASK) & ~PMASK;
        ridx_q  <= '0;
        rperm_q <= '0;
        chg_q   <= 1'b0;
      end
      art_pkg::A_ADDSET: begin
        if (item_q.cmd == art_pkg::CMD_ADD) begin
          lo_q <= {1'b0, item_q.address};
          hi_q <= {2'b00, item_q.end_address};
        end else begin
          lo_q <= {1'b0, lo_q[31:0]};
          hi_q <= {2'b00, lo_q[31:0] + rlen_q[31:0]};
        end
      end
      art_pkg::A_PREP: begin
        idx_q <= '0;
        case (cmd_i.scan)
          art_pkg::SC_LOOK: lo_q <= {1'b0, item_q.address};
          art_pkg::SC_CHECK: begin
            lo_q   <= {1'b0, item_q.address};
            hi_q   <= {2'b00, item_q.address} + {2'b00, item_q.length};
            iter_q <= '0;
          end
          art_pkg::SC_UNMAP, art_pkg::SC_HINT: begin
            lo_q <= {1'b0, item_q.address};
            hi_q <= {2'b00, item_q.address} + {1'b0, rlen_q};
          end
          art_pkg::SC_FIT: hi_q <= {1'b0, lo_q} + {1'b0, rlen_q};
          default: idx_q <= '0;
        endcase
      end
      art_pkg::A_NEXT, art_pkg::A_UNMAP, art_pkg::A_SPLIT2: idx_q <= idx_q + IW'(1);
      art_pkg::A_CHAIN: begin
        idx_q  <= '0;
        iter_q <= iter_q + ITW'(1);
        if (cmd_i.scan == art_pkg::SC_FIT) lo_q <= (en33 + PMASK) & ~PMASK;
        else lo_q <= en33;
      end
      art_pkg::A_FITINIT: begin
        lo_q   <= {1'b0, wbase_q};
        iter_q <= '0;
      end
      art_pkg::A_LOOKOK: begin
        ridx_q  <= idx_q;
        rperm_q <= rd_q.perm;
      end
      art_pkg::A_FINISH: begin
        out_q.status             <= cmd_i.st;
        out_q.result_address     <= (cmd_i.st == art_pkg::ST_OK &&
                                     item_q.cmd == art_pkg::CMD_MAP) ? lo_q[31:0] : '0;
        out_q.region_index       <= 4'(ridx_q);
        out_q.region_permissions <= rperm_q;
        out_q.span_changed       <= chg_q;
      end
      default: idx_q <= idx_q;
    endcase
  end

  assign out_item_o = out_q;

endmodule

### rtl/art_ctrl.sv
// ----------------------------------------------------------------------------
// art_ctrl: address region table controller
// Sequences each command through argument checks, slot scans, table writes
// and the result handshake.
// ----------------------------------------------------------------------------
module art_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output art_pkg::dp_cmd_t  dp_cmd_o,
  input  art_pkg::dp_stat_t dp_stat_i
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DISP  = 15'b000000000000010,
    S_ASET  = 15'b000000000000100,
    S_ACHK  = 15'b000000000001000,
    S_CCHK  = 15'b000000000010000,
    S_UCHK  = 15'b000000000100000,
    S_HCHK  = 15'b000000001000000,
    S_FPREP = 15'b000000010000000,
    S_FCHK  = 15'b000000100000000,
    S_RD    = 15'b000001000000000,
    S_EV    = 15'b000010000000000,
    S_SPLIT = 15'b000100000000000,
    S_UDONE = 15'b001000000000000,
    S_ALLOC = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  art_pkg::scan_e scan_q, scan_d;
  logic [2:0] st_q, st_d;
  logic out_valid_q, out_valid_d;
  art_pkg::act_e act;
  logic mark;

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    st_d    = st_q;
    act     = art_pkg::A_NONE;
    mark    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act     = art_pkg::A_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FIN;
        st_d    = art_pkg::ST_BAD;
        case (dp_stat_i.cmd)
          art_pkg::CMD_CLEAR: begin
            act  = art_pkg::A_CLEAR;
            st_d = art_pkg::ST_OK;
          end
          art_pkg::CMD_ADD: state_d = S_ASET;
          art_pkg::CMD_LOOKUP: begin
            act = art_pkg::A_PREP; scan_d = art_pkg::SC_LOOK; state_d = S_RD;
          end
          art_pkg::CMD_CHECK: begin
            act = art_pkg::A_PREP; scan_d = art_pkg::SC_CHECK; state_d = S_CCHK;
          end
          art_pkg::CMD_UNMAP: begin
            act = art_pkg::A_PREP; scan_d = art_pkg::SC_UNMAP; state_d = S_UCHK;
          end
          art_pkg::CMD_MAP: begin
            if (!dp_stat_i.map_bad) begin
              act = art_pkg::A_PREP;
              if (dp_stat_i.fixed) begin
                scan_d = art_pkg::SC_UNMAP; state_d = S_UCHK;
              end else begin
                scan_d = art_pkg::SC_HINT; state_d = S_HCHK;
              end
            end
          end
          default: st_d = art_pkg::ST_BAD;
        endcase
      end
      S_ASET: begin
        act = art_pkg::A_ADDSET; state_d = S_ACHK;
      end
      S_ACHK: begin
        if (dp_stat_i.add_bad) begin
          st_d = art_pkg::ST_BAD; state_d = S_FIN;
        end else begin
          act = art_pkg::A_PREP; scan_d = art_pkg::SC_ADD; state_d = S_RD;
        end
      end
      S_CCHK: begin
        if (dp_stat_i.check_bad) begin
          st_d = art_pkg::ST_BAD; state_d = S_FIN;
        end else state_d = S_RD;
      end
      S_UCHK: begin
        if (dp_stat_i.unmap_bad) begin
          st_d = art_pkg::ST_BAD; state_d = S_FIN;
        end else state_d = S_RD;
      end
      S_HCHK: begin
        if (dp_stat_i.hint_ok) state_d = S_RD;
        else begin
          act = art_pkg::A_FITINIT; scan_d = art_pkg::SC_FIT; state_d = S_FPREP;
        end
      end
      S_FPREP: begin
        act = art_pkg::A_PREP; state_d = S_FCHK;
      end
      S_FCHK: begin
        if (dp_stat_i.fit_over) begin
          st_d = art_pkg::ST_NOSPACE; state_d = S_FIN;
        end else state_d = S_RD;
      end
      S_RD: begin
        act = art_pkg::A_READ; state_d = S_EV;
      end
      S_EV: begin
        if (!dp_stat_i.hit) begin
          act     = art_pkg::A_NEXT;
          state_d = S_RD;
          if (dp_stat_i.last) begin
            case (scan_q)
              art_pkg::SC_ADD:   state_d = S_ALLOC;
              art_pkg::SC_UNMAP: state_d = S_UDONE;
              art_pkg::SC_HINT, art_pkg::SC_FIT: state_d = S_ASET;
              default: begin
                st_d = art_pkg::ST_MISS; state_d = S_FIN;
              end
            endcase
          end
        end else begin
          case (scan_q)
            art_pkg::SC_ADD: begin
              st_d = art_pkg::ST_OVERLAP; state_d = S_FIN;
            end
            art_pkg::SC_LOOK: begin
              act = art_pkg::A_LOOKOK; st_d = art_pkg::ST_OK; state_d = S_FIN;
            end
            art_pkg::SC_CHECK: begin
              state_d = S_FIN;
              if (!dp_stat_i.perm_ok) st_d = art_pkg::ST_MISS;
              else if (dp_stat_i.chain_done) st_d = art_pkg::ST_OK;
              else if (dp_stat_i.iter_last) st_d = art_pkg::ST_MISS;
              else begin
                act = art_pkg::A_CHAIN; state_d = S_RD;
              end
            end
            art_pkg::SC_HINT: begin
              act = art_pkg::A_FITINIT; scan_d = art_pkg::SC_FIT; state_d = S_FPREP;
            end
            art_pkg::SC_FIT: begin
              if (dp_stat_i.iter_last) begin
                st_d = art_pkg::ST_NOSPACE; state_d = S_FIN;
              end else begin
                act = art_pkg::A_CHAIN; state_d = S_FPREP;
              end
            end
            default: begin
              mark = 1'b1;
              if (!dp_stat_i.split) begin
                act     = art_pkg::A_UNMAP;
                state_d = dp_stat_i.last ? S_UDONE : S_RD;
              end else if (dp_stat_i.free_none) begin
                st_d = art_pkg::ST_FULL; state_d = S_FIN;
              end else begin
                act = art_pkg::A_SPLIT1; state_d = S_SPLIT;
              end
            end
          endcase
        end
      end
      S_SPLIT: begin
        act     = art_pkg::A_SPLIT2;
        state_d = dp_stat_i.last ? S_UDONE : S_RD;
      end
      S_UDONE: begin
        if (dp_stat_i.cmd == art_pkg::CMD_MAP) state_d = S_ASET;
        else begin
          st_d = art_pkg::ST_OK; state_d = S_FIN;
        end
      end
      S_ALLOC: begin
        state_d = S_FIN;
        if (dp_stat_i.free_none) st_d = art_pkg::ST_FULL;
        else begin
          act = art_pkg::A_ALLOC; st_d = art_pkg::ST_OK;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          act = art_pkg::A_FINISH; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (act == art_pkg::A_FINISH) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= art_pkg::SC_ADD;
      st_q        <= art_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign dp_cmd_o.act  = act;
  assign dp_cmd_o.scan = scan_d;
  assign dp_cmd_o.mark = mark;
  assign dp_cmd_o.st   = st_q;
  assign in_ready_o    = state_q == S_IDLE;
  assign out_valid_o   = out_valid_q;

endmodule

### rtl/address_region_table.sv
// ----------------------------------------------------------------------------
// address_region_table: table of page-aligned address regions
// Input items carry a command (clear, add, lookup, check, unmap, map) and
// its operands on a valid/ready channel; each item gives exactly one result
// item on a valid/ready output channel. Two configuration registers set the
// window for dynamic mappings through a plain write port.
// One item is worked on at a time. The table sits in a single-port memory
// and each slot visited in a scan passes a read and an evaluate step.
// Clear and rejected arguments run no scan; add, lookup and unmap run at
// most one scan, each split adds one more step; a fixed map runs an unmap
// scan and an add scan. A chained check runs up to REGION_SLOTS+1 scans;
// a first-fit map runs a hint scan when the hint passes its checks, up to
// REGION_SLOTS+1 fit scans, each after a prepare and a check step, and an
// add scan.
// The result waits in an output register; a new item is taken as soon as
// the previous one has reached it, and a stalled receiver only holds the
// block once the next result is ready to replace it.
// Reset empties the table and loads the default window; no clearing pass.
// ----------------------------------------------------------------------------
module address_region_table #(
  parameter int REGION_SLOTS = 16,
  parameter int PAGE_BITS    = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  art_pkg::item_in_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output art_pkg::item_out_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  art_pkg::dp_cmd_t  dp_cmd;
  art_pkg::dp_stat_t dp_stat;

  art_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  art_dp #(
    .REGION_SLOTS (REGION_SLOTS),
    .PAGE_BITS    (PAGE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while previous item still in work");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(dp_cmd.act == art_pkg::A_FINISH))
    else $error("result raised without finishing an item");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (dp_cmd.act == art_pkg::A_NONE || dp_cmd.act == art_pkg::A_LOAD))
    else $error("datapath action issued while idle");

endmodule

### bench/art_checker.sv
// ----------------------------------------------------------------------------
// art_checker: result predictor and scoreboard for address_region_table
// Watches the configuration port and both item channels. Keeps its own copy
// of the region table and the map window, works out the result of every
// accepted input item and compares each result item field by field with the
// oldest outstanding expectation.
// ----------------------------------------------------------------------------
module art_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  art_pkg::item_in_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  art_pkg::item_out_t out_item_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o
);

  localparam int          SLOTS   = 16;
  localparam logic [31:0] PG_MASK = 32'h0000_0fff;

  bit          slot_used [SLOTS];
  logic [31:0] slot_lo   [SLOTS];
  logic [31:0] slot_hi   [SLOTS];
  logic [2:0]  slot_perm [SLOTS];
  logic [31:0] win_base, win_end;
  art_pkg::item_out_t expected_q[$];

  function automatic longint unsigned page_up(longint unsigned v);
    return (v + 64'hfff) & ~64'hfff;
  endfunction

  function automatic int overlap_slot(longint unsigned s, longint unsigned e);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && s < slot_hi[i] && e > slot_lo[i]) return i;
    return -1;
  endfunction

  function automatic int empty_slot();
    for (int i = 0; i < SLOTS; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic int holding_slot(logic [31:0] a);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && a >= slot_lo[i] && a < slot_hi[i]) return i;
    return -1;
  endfunction

  function automatic logic [2:0] add_region(logic [31:0] s, logic [31:0] e,
                                            logic [2:0] p);
    int f;
    if (s >= e || (s & PG_MASK) != 0 || (e & PG_MASK) != 0) return art_pkg::ST_BAD;
    if (overlap_slot(s, e) >= 0) return art_pkg::ST_OVERLAP;
    f = empty_slot();
    if (f < 0) return art_pkg::ST_FULL;
    slot_used[f] = 1'b1;
    slot_lo[f]   = s;
    slot_hi[f]   = e;
    slot_perm[f] = p;
    return art_pkg::ST_OK;
  endfunction

  function automatic logic [2:0] check_cover(logic [31:0] a, logic [31:0] len,
                                             logic [2:0] need);
    longint unsigned span_end;
    logic [31:0] cur;
    int k;
    span_end = longint'(a) + longint'(len);
    cur = a;
    if (len == 0 || span_end > 64'hffff_ffff) return art_pkg::ST_BAD;
    for (int n = 0; n <= SLOTS; n++) begin
      k = holding_slot(cur);
      if (k < 0 || (slot_perm[k] & need) != need) return art_pkg::ST_MISS;
      if (span_end <= slot_hi[k]) return art_pkg::ST_OK;
      cur = slot_hi[k];
    end
    return art_pkg::ST_MISS;
  endfunction

  function automatic logic [2:0] unmap_range(logic [31:0] a, logic [31:0] len,
                                             inout logic chg);
    longint unsigned e64;
    logic [31:0] e, vs, ve, cs, ce;
    int f;
    if ((a & PG_MASK) != 0 || len == 0) return art_pkg::ST_BAD;
    e64 = longint'(a) + page_up(len);
    if (e64 > 64'hffff_ffff || a < win_base || e64 > win_end) return art_pkg::ST_BAD;
    e = e64[31:0];
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i]) continue;
      vs = slot_lo[i];
      ve = slot_hi[i];
      if (ve <= a || vs >= e) continue;
      cs = (a > vs) ? a : vs;
      ce = (e < ve) ? e : ve;
      if (cs >= ce) continue;
      chg = 1'b1;
      if (cs == vs && ce == ve) begin
        slot_used[i] = 1'b0;
      end else if (cs == vs) begin
        slot_lo[i] = ce;
      end else if (ce == ve) begin
        slot_hi[i] = cs;
      end else begin
        f = empty_slot();
        if (f < 0) return art_pkg::ST_FULL;
        slot_used[f] = 1'b1;
        slot_lo[f]   = ce;
        slot_hi[f]   = ve;
        slot_perm[f] = slot_perm[i];
        slot_hi[i]   = cs;
      end
    end
    return art_pkg::ST_OK;
  endfunction

  function automatic logic [2:0] map_range(logic [31:0] hint, logic [31:0] len,
                                           logic [2:0] p, logic fx,
                                           inout logic chg,
                                           inout logic [31:0] placed);
    longint unsigned rlen, cand;
    logic [31:0] chosen;
    bit found;
    logic [2:0] st;
    int k;
    chosen = '0;
    found  = 0;
    if (len == 0 || p == 0) return art_pkg::ST_BAD;
    rlen = page_up(len);
    if (fx) begin
      if ((hint & PG_MASK) != 0 || hint < win_base || longint'(hint) + rlen > win_end)
        return art_pkg::ST_BAD;
      st = unmap_range(hint, len, chg);
      if (st != art_pkg::ST_OK) return st;
      chosen = hint;
    end else begin
      if (hint != 0 && (hint & PG_MASK) == 0 && hint >= win_base &&
          longint'(hint) + rlen <= win_end &&
          overlap_slot(hint, longint'(hint) + rlen) < 0) begin
        chosen = hint;
        found  = 1;
      end
      cand = win_base;
      for (int n = 0; !found && n <= SLOTS; n++) begin
        if (cand + rlen > win_end) break;
        k = overlap_slot(cand, cand + rlen);
        if (k < 0) begin
          chosen = cand[31:0];
          found  = 1;
        end else begin
          cand = page_up(slot_hi[k]);
        end
      end
      if (!found) return art_pkg::ST_NOSPACE;
    end
    st = add_region(chosen, chosen + rlen[31:0], p);
    if (st == art_pkg::ST_OK) placed = chosen;
    return st;
  endfunction

  function automatic art_pkg::item_out_t predict_result(art_pkg::item_in_t it);
    art_pkg::item_out_t r;
    logic chg;
    logic [31:0] placed;
    int k;
    r = '0;
    chg = 1'b0;
    placed = '0;
    case (it.cmd)
      art_pkg::CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        r.status = art_pkg::ST_OK;
      end
      art_pkg::CMD_ADD: r.status = add_region(it.address, it.end_address, it.permissions);
      art_pkg::CMD_LOOKUP: begin
        k = holding_slot(it.address);
        if (k < 0) begin
          r.status = art_pkg::ST_MISS;
        end else begin
          r.status             = art_pkg::ST_OK;
          r.region_index       = k[3:0];
          r.region_permissions = slot_perm[k];
        end
      end
      art_pkg::CMD_CHECK: r.status = check_cover(it.address, it.length, it.permissions);
      art_pkg::CMD_UNMAP: r.status = unmap_range(it.address, it.length, chg);
      art_pkg::CMD_MAP: r.status = map_range(it.address, it.length, it.permissions,
                                             it.fixed_place, chg, placed);
      default: r.status = art_pkg::ST_BAD;
    endcase
    r.result_address = placed;
    r.span_changed   = chg;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    art_pkg::item_out_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_lo[i]   = '0;
        slot_hi[i]   = '0;
        slot_perm[i] = '0;
      end
      win_base = art_pkg::WIN_BASE_RST;
      win_end  = art_pkg::WIN_END_RST;
      expected_q.delete();
      fail_count_o = 0;
      results_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_item_i.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_item_i.status);
            fail_count_o++;
          end
          if (out_item_i.result_address !== exp_r.result_address) begin
            $error("result_address: expected %h, got %h",
                   exp_r.result_address, out_item_i.result_address);
            fail_count_o++;
          end
          if (out_item_i.region_index !== exp_r.region_index) begin
            $error("region_index: expected %0d, got %0d",
                   exp_r.region_index, out_item_i.region_index);
            fail_count_o++;
          end
          if (out_item_i.region_permissions !== exp_r.region_permissions) begin
            $error("region_permissions: expected %0d, got %0d",
                   exp_r.region_permissions, out_item_i.region_permissions);
            fail_count_o++;
          end
          if (out_item_i.span_changed !== exp_r.span_changed) begin
            $error("span_changed: expected %0d, got %0d",
                   exp_r.span_changed, out_item_i.span_changed);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == art_pkg::CFG_WIN_BASE) win_base = cfg_data_i;
        else win_end = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_result(in_item_i));
    end
    pending_o = expected_q.size();
  end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for address_region_table
// Drives directed and random command items through several map window
// settings with random idling on both channels; art_checker predicts and
// compares every result item. Prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT = 4_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  art_pkg::item_in_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  art_pkg::item_out_t out_item;
  logic               cfg_we = 1'b0;
  logic               cfg_index = art_pkg::CFG_WIN_BASE;
  logic [31:0]        cfg_data = '0;
  int                 fail_count, pending, results;
  int                 send_idle_pct, recv_idle_pct, sent, cycles;
  logic [31:0]        base_now;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  address_region_table u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  art_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_item_i(out_item),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic art_pkg::item_in_t mk(logic [2:0] c, logic [31:0] a, logic [31:0] e,
                                           logic [31:0] len, logic [2:0] p, logic fx);
    art_pkg::item_in_t it;
    it.cmd = c; it.address = a; it.end_address = e;
    it.length = len; it.permissions = p; it.fixed_place = fx;
    return it;
  endfunction

  function automatic logic [31:0] near_page();
    return (base_now & ~32'hfff) + ($urandom_range(0, 40) << 12);
  endfunction

  function automatic logic [31:0] span_len();
    logic [31:0] l;
    l = $urandom_range(1, 8) << 12;
    if ($urandom_range(3) == 0) l = l - $urandom_range(4095);
    if ($urandom_range(60) == 0) l = ($urandom_range(1)) ? 32'h0 : $urandom;
    return l;
  endfunction

  function automatic art_pkg::item_in_t random_item();
    art_pkg::item_in_t it;
    int pick;
    logic [31:0] a;
    it = '0;
    pick = $urandom_range(99);
    a = near_page();
    it.permissions = 3'($urandom_range(7));
    it.fixed_place = 1'($urandom_range(1));
    it.end_address = $urandom;
    if (pick < 25) begin
      it.cmd = art_pkg::CMD_MAP;
      it.address = ($urandom_range(2) == 0) ? 32'h0 : a;
      it.length = span_len();
      if ($urandom_range(20) == 0) it.permissions = 3'd0;
    end else if (pick < 45) begin
      it.cmd = art_pkg::CMD_ADD;
      it.address = a;
      it.end_address = a + ($urandom_range(1, 6) << 12);
      if ($urandom_range(15) == 0) it.end_address = it.end_address ^ $urandom_range(4095);
      if ($urandom_range(15) == 0) it.end_address = a;
    end else if (pick < 60) begin
      it.cmd = art_pkg::CMD_UNMAP;
      it.address = ($urandom_range(10) == 0) ? a + $urandom_range(1, 4095) : a;
      it.length = span_len();
    end else if (pick < 75) begin
      it.cmd = art_pkg::CMD_LOOKUP;
      it.address = a + $urandom_range(4095);
    end else if (pick < 90) begin
      it.cmd = art_pkg::CMD_CHECK;
      it.address = a + $urandom_range(4095);
      it.length = span_len();
    end else if (pick < 93) begin
      it.cmd = art_pkg::CMD_CLEAR;
    end else if (pick < 95) begin
      it.cmd = 3'($urandom_range(6, 7));
    end else begin
      it = art_pkg::item_in_t'({$urandom, $urandom, $urandom, $urandom});
    end
    return it;
  endfunction

  task automatic send_item(art_pkg::item_in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_window(logic [31:0] b, logic [31:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= art_pkg::CFG_WIN_BASE;
    cfg_data  <= b;
    @(posedge clk_i);
    cfg_index <= art_pkg::CFG_WIN_END;
    cfg_data  <= e;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    base_now = b;
  endtask

  art_pkg::item_in_t directed[$];
  logic [31:0] win_b[6] = '{32'h2000_0000, 32'h0000_0000, 32'hffff_0000,
                            32'h1000_0800, 32'h5000_0000, 32'h4000_0000};
  logic [31:0] win_e[6] = '{32'h3f00_0000, 32'hffff_ffff, 32'hffff_ffff,
                            32'h1004_0000, 32'h1000_0000, 32'h4001_0000};

  initial begin
    send_idle_pct = 20;
    recv_idle_pct = 47;
    base_now = art_pkg::WIN_BASE_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      mk(art_pkg::CMD_CLEAR, 0, 0, 0, 0, 0),
      mk(art_pkg::CMD_ADD, 32'h0, 32'h1000, 0, 3'd7, 0),
      mk(art_pkg::CMD_ADD, 32'hffff_e000, 32'hffff_f000, 0, 3'd1, 0),
      mk(art_pkg::CMD_ADD, 32'h2000_0800, 32'h2000_2000, 0, 3'd1, 0),
      mk(art_pkg::CMD_ADD, 32'h2000_3000, 32'h2000_3000, 0, 3'd1, 0),
      mk(art_pkg::CMD_ADD, 32'h2000_0000, 32'h2000_4000, 0, 3'd3, 0),
      mk(art_pkg::CMD_ADD, 32'h2000_4000, 32'h2000_8000, 0, 3'd1, 0),
      mk(art_pkg::CMD_ADD, 32'h2000_1000, 32'h2000_2000, 0, 3'd1, 0),
      mk(art_pkg::CMD_LOOKUP, 32'hffff_efff, 0, 0, 0, 0),
      mk(art_pkg::CMD_LOOKUP, 32'hffff_ffff, 0, 0, 0, 0),
      mk(art_pkg::CMD_CHECK, 32'h2000_0000, 0, 32'h0, 3'd1, 0),
      mk(art_pkg::CMD_CHECK, 32'hffff_0000, 0, 32'h0002_0000, 3'd1, 0),
      mk(art_pkg::CMD_CHECK, 32'h2000_0010, 0, 32'h6000, 3'd1, 0),
      mk(art_pkg::CMD_CHECK, 32'h2000_0010, 0, 32'h6000, 3'd2, 0),
      mk(art_pkg::CMD_UNMAP, 32'h2000_0800, 0, 32'h1000, 0, 0),
      mk(art_pkg::CMD_UNMAP, 32'h1000_0000, 0, 32'h1000, 0, 0),
      mk(art_pkg::CMD_UNMAP, 32'h2000_5000, 0, 32'h1001, 0, 0),
      mk(art_pkg::CMD_MAP, 32'h0, 0, 32'h0, 3'd1, 0),
      mk(art_pkg::CMD_MAP, 32'h0, 0, 32'h1000, 3'd0, 0),
      mk(art_pkg::CMD_MAP, 32'h0, 0, 32'hffff_ffff, 3'd1, 0),
      mk(art_pkg::CMD_MAP, 32'h2000_1000, 0, 32'h2000, 3'd5, 1),
      mk(art_pkg::CMD_MAP, 32'h3000_0000, 0, 32'h10, 3'd2, 0),
      mk(art_pkg::CMD_MAP, 32'h2000_0000, 0, 32'h3000, 3'd4, 0),
      mk(art_pkg::CMD_CLEAR + 3'd6, 0, 0, 0, 0, 0),
      mk(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 3'd7, 1)
    };
    foreach (directed[i]) send_item(directed[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 20; recv_idle_pct = 47;
      end else if (ph < 4) begin
        send_idle_pct = 47; recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      set_window(win_b[ph], win_e[ph]);
      for (int n = 0; n < 300; n++) begin
        send_item(random_item());
        if (n == 150) drain();
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("Ran %0d command items, %0d results checked, over six map windows",
             sent, results);
    $display("including the full and unaligned windows and all handshake idle mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
